[rtl/vba_pkg.sv]
// types, constants and arctangent table for the vector bearing angle block
package vba_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int ProdW  = 34;
  localparam int PreSh  = 24;
  localparam int CordW  = ProdW + PreSh + 3;
  localparam int ZW     = 32;
  localparam int AngW   = 15;
  localparam int AtanLen = 24;

  localparam logic signed [ZW-1:0] DegZ90  = 32'sd377487360;
  localparam logic signed [ZW-1:0] DegZ180 = 32'sd754974720;
  localparam logic [AngW-1:0] FullQ6    = 15'd23040;
  localparam logic [AngW-1:0] HalfQ6    = 15'd11520;
  localparam logic [AngW-1:0] QuarterQ6 = 15'd5760;

  typedef enum logic [1:0] {
    CfgCenterX = 2'd0,
    CfgCenterY = 2'd1,
    CfgFacingX = 2'd2,
    CfgFacingY = 2'd3
  } vba_cfg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } vba_in_t;

  typedef struct packed {
    logic [AngW-1:0] angle_q6;
    logic            degenerate;
  } vba_out_t;

  // side info that travels alongside the cordic datapath
  typedef struct packed {
    logic            deg;
    logic            fixed;
    logic            cross_pos;
    logic [AngW-1:0] fixed_theta;
  } vba_side_t;

  // atan(2^-i) in units of 2^-22 degree
  function automatic logic signed [ZW-1:0] atan_z(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:  r = 32'sd188743680;
      5'd1:  r = 32'sd111421900;
      5'd2:  r = 32'sd58872272;
      5'd3:  r = 32'sd29884485;
      5'd4:  r = 32'sd15000234;
      5'd5:  r = 32'sd7507429;
      5'd6:  r = 32'sd3754631;
      5'd7:  r = 32'sd1877430;
      5'd8:  r = 32'sd938729;
      5'd9:  r = 32'sd469366;
      5'd10: r = 32'sd234683;
      5'd11: r = 32'sd117342;
      5'd12: r = 32'sd58671;
      5'd13: r = 32'sd29335;
      5'd14: r = 32'sd14668;
      5'd15: r = 32'sd7334;
      5'd16: r = 32'sd3667;
      5'd17: r = 32'sd1833;
      5'd18: r = 32'sd917;
      5'd19: r = 32'sd458;
      5'd20: r = 32'sd229;
      5'd21: r = 32'sd115;
      5'd22: r = 32'sd57;
      5'd23: r = 32'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/vector_bearing_angle.sv]
// top level: pipelined full-circle bearing angle of a target point
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | in        | in_valid_i / in_stall_o | in_data_i  (target_x/_y)
//   out     | out       | out_valid_o/ out_stall_i| out_data_o (angle_q6, degenerate)
//   cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one transaction per cycle while the output is not stalled; the stages are difference,
// multiply, dot/cross, one cordic stage per step and the round/fold output register, so a
// new transaction can enter while earlier ones are still in flight.
// rst_ni clears all valid bits and loads the reset geometry.
// each stage holds while the stage after it is full and stalled; empty stages
// still fill, so bubbles close up behind a stalled output.
module vector_bearing_angle
  import vba_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vba_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vba_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int Steps = (CORDIC_STEPS < 1) ? 1 :
                         (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;

  // configuration registers
  logic signed [CoordW-1:0] center_x_q, center_y_q, facing_x_q, facing_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= 16'sd400;
      center_y_q <= 16'sd300;
      facing_x_q <= 16'sd400;
      facing_y_q <= 16'sd70;
    end else if (cfg_we_i) begin
      unique case (vba_cfg_e'(cfg_idx_i))
        CfgCenterX: center_x_q <= cfg_data_i;
        CfgCenterY: center_y_q <= cfg_data_i;
        CfgFacingX: facing_x_q <= cfg_data_i;
        CfgFacingY: facing_y_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // stage enables, computed back from the output register
  logic               out_en, s3_en, s2_en, s1_en;
  logic [Steps-1:0]   cv_q;
  logic [Steps-1:0]   en_c;
  logic               s1_v_q, s2_v_q, s3_v_q;

  always_comb begin
    logic nxt;
    out_en = !out_valid_o || !out_stall_i;
    nxt = out_en;
    for (int k = Steps - 1; k >= 0; k--) begin
      en_c[k] = !cv_q[k] || nxt;
      nxt = en_c[k];
    end
    s3_en = !s3_v_q || en_c[0];
    s2_en = !s2_v_q || s3_en;
    s1_en = !s1_v_q || s2_en;
  end

  assign in_stall_o = !s1_en;

  // stage 1: vectors relative to the center
  logic signed [DiffW-1:0] tx_q, ty_q, lx_q, ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      tx_q <= DiffW'(in_data_i.target_x) - DiffW'(center_x_q);
      ty_q <= DiffW'(in_data_i.target_y) - DiffW'(center_y_q);
      lx_q <= DiffW'(facing_x_q) - DiffW'(center_x_q);
      ly_q <= DiffW'(facing_y_q) - DiffW'(center_y_q);
    end
  end

  // stage 2: the four products
  logic signed [ProdW-1:0] p_lxtx_q, p_lyty_q, p_lxty_q, p_lytx_q;
  logic                    deg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      p_lxtx_q <= ProdW'(lx_q) * ProdW'(tx_q);
      p_lyty_q <= ProdW'(ly_q) * ProdW'(ty_q);
      p_lxty_q <= ProdW'(lx_q) * ProdW'(ty_q);
      p_lytx_q <= ProdW'(ly_q) * ProdW'(tx_q);
      deg2_q   <= (lx_q == '0 && ly_q == '0) || (tx_q == '0 && ty_q == '0);
    end
  end

  // stage 3: dot and cross, special cases, cordic start point
  logic signed [ProdW-1:0] dot, crs, acr, x0v, y0v;
  logic signed [ZW-1:0]    z0v;
  vba_side_t               side3_d;

  always_comb begin
    dot   = p_lxtx_q + p_lyty_q;
    crs   = p_lxty_q - p_lytx_q;
    acr   = crs[ProdW-1] ? -crs : crs;
    side3_d.deg         = deg2_q;
    side3_d.cross_pos   = !crs[ProdW-1] && (crs != '0);
    side3_d.fixed       = 1'b1;
    side3_d.fixed_theta = QuarterQ6;
    x0v = dot;
    y0v = acr;
    z0v = '0;
    priority if (deg2_q) begin
      side3_d.fixed_theta = QuarterQ6;
    end else if (crs == '0) begin
      side3_d.fixed_theta = (!dot[ProdW-1] && dot != '0) ? '0 : HalfQ6;
    end else if (dot == '0) begin
      side3_d.fixed_theta = QuarterQ6;
    end else if (!dot[ProdW-1]) begin
      side3_d.fixed = 1'b0;
    end else begin
      // obtuse: rotate by -90 degrees first
      side3_d.fixed = 1'b0;
      x0v = acr;
      y0v = -dot;
      z0v = DegZ90;
    end
  end

  logic signed [CordW-1:0] x3_q, y3_q;
  logic signed [ZW-1:0]    z3_q;
  vba_side_t               side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) begin
      x3_q    <= CordW'(x0v) <<< PreSh;
      y3_q    <= CordW'(y0v) <<< PreSh;
      z3_q    <= z0v;
      side3_q <= side3_d;
    end
  end

  // cordic vectoring, one micro-rotation per stage
  logic signed [CordW-1:0] cx_q [Steps];
  logic signed [CordW-1:0] cy_q [Steps];
  logic signed [ZW-1:0]    cz_q [Steps];
  vba_side_t               cs_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    logic signed [CordW-1:0] xp, yp;
    logic signed [ZW-1:0]    zp;
    vba_side_t               sp;
    logic                    vp;

    if (i == 0) begin : g_first
      assign xp = x3_q;
      assign yp = y3_q;
      assign zp = z3_q;
      assign sp = side3_q;
      assign vp = s3_v_q;
    end else begin : g_next
      assign xp = cx_q[i-1];
      assign yp = cy_q[i-1];
      assign zp = cz_q[i-1];
      assign sp = cs_q[i-1];
      assign vp = cv_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (en_c[i]) begin
        cv_q[i] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_c[i] && vp) begin
        if (!yp[CordW-1]) begin
          cx_q[i] <= xp + (yp >>> i);
          cy_q[i] <= yp - (xp >>> i);
          cz_q[i] <= zp + atan_z(5'(i));
        end else begin
          cx_q[i] <= xp - (yp >>> i);
          cy_q[i] <= yp + (xp >>> i);
          cz_q[i] <= zp - atan_z(5'(i));
        end
        cs_q[i] <= sp;
      end
    end
  end

  // output stage: clamp, round to 1/64 degree, fold by cross sign
  logic signed [ZW-1:0] zc, zr;
  logic [AngW-1:0]      theta, ang;
  vba_side_t            sl;
  vba_out_t             out_d;

  always_comb begin
    sl = cs_q[Steps-1];
    zc = cz_q[Steps-1];
    if (zc[ZW-1]) begin
      zc = '0;
    end else if (zc > DegZ180) begin
      zc = DegZ180;
    end
    zr    = zc + 32'sd32768;
    theta = sl.fixed ? sl.fixed_theta : AngW'(zr >>> 16);
    ang   = sl.cross_pos ? (FullQ6 - theta) : theta;
    if (ang >= FullQ6) begin
      ang = '0;
    end
    out_d.angle_q6   = sl.deg ? QuarterQ6 : ang;
    out_d.degenerate = sl.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_en) begin
      out_valid_o <= cv_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && cv_q[Steps-1]) begin
      out_data_o <= out_d;
    end
  end

endmodule

[rtl/vba_checker.sv]
// port-level checker for the vector bearing angle block, with its bind
module vba_checker
  import vba_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input vba_out_t out_data_o
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("out transaction changed while stalled");

  // input backpressure only comes from a stalled, full output
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output can drain");

  a_deg_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.angle_q6 == QuarterQ6)
    else $error("degenerate result without 90 degrees");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.angle_q6 < FullQ6)
    else $error("angle not below full circle");

endmodule

bind vector_bearing_angle vba_checker u_vba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
